>>> sv/rotated_rect_window_command_gen_core_assert.svh
// assertion macros for the checks of the core file
`ifndef ROTATED_RECT_WINDOW_COMMAND_GEN_CORE_ASSERT_SVH
`define ROTATED_RECT_WINDOW_COMMAND_GEN_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RRW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrw assertion failed");

// antecedent implies consequent in the next cycle
`define RRW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrw assertion failed");

`endif

>>> sv/rrw_pkg.sv
package rrw_pkg;

    // coordinate width default
    localparam int COORD_BITS_DEFAULT = 12;

    // register field widths
    localparam int ROT_BITS   = 2;
    localparam int PANEL_BITS = 11;
    localparam int SIZE_BITS  = 11;
    localparam int CFG_BITS   = 11;
    localparam int INDEX_BITS = 2;

    // register indexes
    localparam logic [INDEX_BITS-1:0] REG_ROTATION      = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_PANEL_COLUMNS = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_PANEL_ROWS    = 2'd2;

    // register reset values
    localparam logic [ROT_BITS-1:0]   ROTATION_RESET = 2'd0;
    localparam logic [PANEL_BITS-1:0] COLUMNS_RESET  = 11'd320;
    localparam logic [PANEL_BITS-1:0] ROWS_RESET     = 11'd480;

    // rotation codes
    localparam logic [ROT_BITS-1:0] ROT_LANDSCAPE = 2'd0;
    localparam logic [ROT_BITS-1:0] ROT_LEFT      = 2'd1;
    localparam logic [ROT_BITS-1:0] ROT_RIGHT     = 2'd2;
    localparam logic [ROT_BITS-1:0] ROT_FLIPPED   = 2'd3;

    // bus commands
    localparam logic [7:0] CMD_COLUMN = 8'h2a;
    localparam logic [7:0] CMD_ROW    = 8'h2b;
    localparam logic [7:0] CMD_MEMORY = 8'h2c;

    // word slots of one sequence
    localparam int WORD_COUNT = 11;
    localparam int SLOT_BITS  = $clog2(WORD_COUNT);
    localparam logic [SLOT_BITS-1:0] SLOT_CMD_COL = 4'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_C0_HI   = 4'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_C0_LO   = 4'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_C1_HI   = 4'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_C1_LO   = 4'd4;
    localparam logic [SLOT_BITS-1:0] SLOT_CMD_ROW = 4'd5;
    localparam logic [SLOT_BITS-1:0] SLOT_R0_HI   = 4'd6;
    localparam logic [SLOT_BITS-1:0] SLOT_R0_LO   = 4'd7;
    localparam logic [SLOT_BITS-1:0] SLOT_R1_HI   = 4'd8;
    localparam logic [SLOT_BITS-1:0] SLOT_R1_LO   = 4'd9;
    localparam logic [SLOT_BITS-1:0] SLOT_CMD_MEM = 4'd10;

    // window queue depth
    localparam int QUEUE_DEPTH = 2;

    // window words are sent as 16-bit two's complement
    localparam int WIN_BITS = 16;

    typedef struct packed {
        logic [WIN_BITS-1:0] c0;
        logic [WIN_BITS-1:0] c1;
        logic [WIN_BITS-1:0] r0;
        logic [WIN_BITS-1:0] r1;
    } win_t;

    // front to queue
    typedef struct packed {
        logic push;
        win_t win;
    } q_wr_t;

    // queue status
    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

>>> sv/rrw_front.sv
module rrw_front #(
    parameter int COORD_BITS = rrw_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [COORD_BITS-1:0]           rect_x,
    input  logic signed [COORD_BITS-1:0]           rect_y,
    input  logic [rrw_pkg::SIZE_BITS-1:0]          rect_width,
    input  logic [rrw_pkg::SIZE_BITS-1:0]          rect_height,
    input  logic [rrw_pkg::ROT_BITS-1:0]           rotation,
    input  logic [rrw_pkg::PANEL_BITS-1:0]         panel_columns,
    input  logic [rrw_pkg::PANEL_BITS-1:0]         panel_rows,
    input  rrw_pkg::q_stat_t                       q_stat,
    output rrw_pkg::q_wr_t                         q_wr
);

    localparam int ARITH_BITS = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
    localparam int PB = rrw_pkg::PANEL_BITS;
    localparam int WB = rrw_pkg::WIN_BITS;

    logic signed [ARITH_BITS-1:0] xs, ys, ext_x, ext_y, x_end, y_end;
    logic                         portrait, accepted, advance;
    logic [PB-1:0]                xe_clip, ye_clip;

    logic          s1_valid_reg, s1_valid_next;
    logic [PB-1:0] x_reg, y_reg, xe_reg, ye_reg;

    logic [WB-1:0] x16, y16, xe16, ye16, pw16, ph16;
    rrw_pkg::win_t win;

    // extents for the current rotation
    assign portrait = (rotation == rrw_pkg::ROT_LEFT) || (rotation == rrw_pkg::ROT_RIGHT);
    assign ext_x = $signed({{(ARITH_BITS-PB){1'b0}}, (portrait ? panel_columns : panel_rows)});
    assign ext_y = $signed({{(ARITH_BITS-PB){1'b0}}, (portrait ? panel_rows : panel_columns)});

    // reject check and clipped far edges
    assign xs = $signed({{(ARITH_BITS-COORD_BITS){rect_x[COORD_BITS-1]}}, rect_x});
    assign ys = $signed({{(ARITH_BITS-COORD_BITS){rect_y[COORD_BITS-1]}}, rect_y});
    assign x_end = xs + $signed({{(ARITH_BITS-rrw_pkg::SIZE_BITS){1'b0}}, rect_width});
    assign y_end = ys + $signed({{(ARITH_BITS-rrw_pkg::SIZE_BITS){1'b0}}, rect_height});
    assign accepted = !xs[ARITH_BITS-1] && !ys[ARITH_BITS-1] && (xs <= ext_x) && (ys <= ext_y);
    assign xe_clip = (x_end > ext_x) ? ext_x[PB-1:0] : x_end[PB-1:0];
    assign ye_clip = (y_end > ext_y) ? ext_y[PB-1:0] : y_end[PB-1:0];

    // stage moves when empty or when the queue takes its window
    assign advance  = !s1_valid_reg || !q_stat.full;
    assign in_stall = !advance;
    assign s1_valid_next = advance ? (in_valid && accepted) : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg  <= xs[PB-1:0];
            y_reg  <= ys[PB-1:0];
            xe_reg <= xe_clip;
            ye_reg <= ye_clip;
        end
    end

    // map to panel window
    assign x16  = {{(WB-PB){1'b0}}, x_reg};
    assign y16  = {{(WB-PB){1'b0}}, y_reg};
    assign xe16 = {{(WB-PB){1'b0}}, xe_reg};
    assign ye16 = {{(WB-PB){1'b0}}, ye_reg};
    assign pw16 = {{(WB-PB){1'b0}}, panel_columns};
    assign ph16 = {{(WB-PB){1'b0}}, panel_rows};

    always_comb
    begin
        unique case (rotation)
            rrw_pkg::ROT_LEFT:
            begin
                win.c0 = x16;
                win.c1 = xe16 - WB'(1);
                win.r0 = y16;
                win.r1 = ye16 - WB'(1);
            end
            rrw_pkg::ROT_RIGHT:
            begin
                win.c0 = pw16 - xe16;
                win.c1 = pw16 + ~x16;
                win.r0 = ph16 - ye16;
                win.r1 = ph16 + ~y16;
            end
            rrw_pkg::ROT_FLIPPED:
            begin
                win.c0 = pw16 - ye16;
                win.c1 = pw16 + ~y16;
                win.r0 = x16;
                win.r1 = xe16 - WB'(1);
            end
            default:
            begin
                win.c0 = y16;
                win.c1 = ye16 - WB'(1);
                win.r0 = ph16 - xe16;
                win.r1 = ph16 + ~x16;
            end
        endcase
    end

    assign q_wr.push = s1_valid_reg && !q_stat.full;
    assign q_wr.win  = win;

endmodule

>>> sv/rrw_queue.sv
module rrw_queue #(
    parameter int DEPTH = rrw_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rrw_pkg::q_wr_t   q_wr,
    input  logic             pop,
    output rrw_pkg::q_stat_t q_stat,
    output rrw_pkg::win_t    head
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    rrw_pkg::win_t       entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == CNT_BITS'(DEPTH));
    assign head         = entry_reg[rd_ptr_reg];

    assign do_push = q_wr.push && !q_stat.full;
    assign do_pop  = pop && q_stat.valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.win;
        end
    end

endmodule

>>> sv/rrw_back.sv
module rrw_back (
    input  logic             clk,
    input  logic             rst_n,
    input  rrw_pkg::q_stat_t q_stat,
    input  rrw_pkg::win_t    head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             is_command,
    output logic [7:0]       bus_byte,
    output logic             last_word
);

    localparam int SB = rrw_pkg::SLOT_BITS;

    logic          cur_valid_reg, cur_valid_next;
    rrw_pkg::win_t cur_reg, cur_next;
    logic [SB-1:0] slot_reg, slot_next;
    logic          out_valid_reg, out_valid_next;
    logic          is_command_reg, last_word_reg;
    logic [7:0]    bus_byte_reg;
    logic          load, emit, refill;
    logic          word_cmd, word_last;
    logic [7:0]    word_byte;

    // output register refills when empty or taken
    assign load   = !out_valid_reg || !out_stall;
    assign emit   = load && cur_valid_reg;
    assign refill = !cur_valid_reg || (emit && (slot_reg == rrw_pkg::SLOT_CMD_MEM));
    assign pop    = refill && q_stat.valid;

    assign cur_valid_next = refill ? q_stat.valid : cur_valid_reg;
    assign cur_next       = pop ? head : cur_reg;
    assign slot_next      = refill ? rrw_pkg::SLOT_CMD_COL
                          : (emit ? slot_reg + SB'(1) : slot_reg);
    assign out_valid_next = load ? cur_valid_reg : out_valid_reg;

    // word for the current slot
    always_comb
    begin
        word_cmd  = 1'b0;
        word_last = 1'b0;
        unique case (slot_reg)
            rrw_pkg::SLOT_CMD_COL:
            begin
                word_cmd  = 1'b1;
                word_byte = rrw_pkg::CMD_COLUMN;
            end
            rrw_pkg::SLOT_C0_HI:   word_byte = cur_reg.c0[15:8];
            rrw_pkg::SLOT_C0_LO:   word_byte = cur_reg.c0[7:0];
            rrw_pkg::SLOT_C1_HI:   word_byte = cur_reg.c1[15:8];
            rrw_pkg::SLOT_C1_LO:   word_byte = cur_reg.c1[7:0];
            rrw_pkg::SLOT_CMD_ROW:
            begin
                word_cmd  = 1'b1;
                word_byte = rrw_pkg::CMD_ROW;
            end
            rrw_pkg::SLOT_R0_HI:   word_byte = cur_reg.r0[15:8];
            rrw_pkg::SLOT_R0_LO:   word_byte = cur_reg.r0[7:0];
            rrw_pkg::SLOT_R1_HI:   word_byte = cur_reg.r1[15:8];
            rrw_pkg::SLOT_R1_LO:   word_byte = cur_reg.r1[7:0];
            rrw_pkg::SLOT_CMD_MEM:
            begin
                word_cmd  = 1'b1;
                word_last = 1'b1;
                word_byte = rrw_pkg::CMD_MEMORY;
            end
            default:               word_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= rrw_pkg::SLOT_CMD_COL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            is_command_reg <= word_cmd;
            bus_byte_reg   <= word_byte;
            last_word_reg  <= word_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_command = is_command_reg;
    assign bus_byte   = bus_byte_reg;
    assign last_word  = last_word_reg;

endmodule

>>> sv/rotated_rect_window_command_gen_core.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  rect_x, rect_y, rect_width, rect_height
// out       output     out_valid/out_stall  is_command, bus_byte, last_word
// cfg       input      cfg_we               cfg_index, cfg_data
//
// each accepted rectangle gives 11 output words from the word sequencer of the back end,
// one per cycle while out_stall is low; a new rectangle can be taken while earlier words go out.
// on its way to the first word a rectangle passes the front stage, the queue and the back end's
// current window and output registers. rejected rectangles are taken but give no words.
// reset is asynchronous, active low; it restores the register defaults and empties the queue.
// an output stall holds the word; input stalls when the front stage holds a window
// and the window queue is full.
`include "rotated_rect_window_command_gen_core_assert.svh"

module rotated_rect_window_command_gen_core #(
    parameter int COORD_BITS  = rrw_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = rrw_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rrw_pkg::INDEX_BITS-1:0]  cfg_index,
    input  logic [rrw_pkg::CFG_BITS-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [COORD_BITS-1:0]    rect_x,
    input  logic signed [COORD_BITS-1:0]    rect_y,
    input  logic [rrw_pkg::SIZE_BITS-1:0]   rect_width,
    input  logic [rrw_pkg::SIZE_BITS-1:0]   rect_height,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            is_command,
    output logic [7:0]                      bus_byte,
    output logic                            last_word
);

    logic [rrw_pkg::ROT_BITS-1:0]   rotation_reg;
    logic [rrw_pkg::PANEL_BITS-1:0] columns_reg, rows_reg;

    rrw_pkg::q_wr_t   q_wr;
    rrw_pkg::q_stat_t q_stat;
    rrw_pkg::win_t    head;
    logic             pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= rrw_pkg::ROTATION_RESET;
            columns_reg  <= rrw_pkg::COLUMNS_RESET;
            rows_reg     <= rrw_pkg::ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rrw_pkg::REG_ROTATION:      rotation_reg <= cfg_data[rrw_pkg::ROT_BITS-1:0];
                rrw_pkg::REG_PANEL_COLUMNS: columns_reg  <= cfg_data;
                rrw_pkg::REG_PANEL_ROWS:    rows_reg     <= cfg_data;
                default:                    rotation_reg <= rotation_reg;
            endcase
        end
    end

    // front: check, clip and map
    rrw_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .rotation     (rotation_reg),
        .panel_columns(columns_reg),
        .panel_rows   (rows_reg),
        .q_stat       (q_stat),
        .q_wr         (q_wr)
    );

    // window queue
    rrw_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .q_stat(q_stat),
        .head  (head)
    );

    // back: word sequencer
    rrw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_command(is_command),
        .bus_byte  (bus_byte),
        .last_word (last_word)
    );

    // checks
    `RRW_ASSERT_NOW(a_push_not_full, q_wr.push, !q_stat.full)
    `RRW_ASSERT_NOW(a_last_is_memory, out_valid && last_word,
        is_command && (bus_byte == rrw_pkg::CMD_MEMORY))
    `RRW_ASSERT_NOW(a_command_byte, out_valid && is_command,
        (bus_byte == rrw_pkg::CMD_COLUMN) || (bus_byte == rrw_pkg::CMD_ROW)
        || (bus_byte == rrw_pkg::CMD_MEMORY))
    `RRW_ASSERT_NEXT(a_stall_holds, out_valid && out_stall,
        out_valid && $stable(bus_byte) && $stable(is_command) && $stable(last_word))

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int COORD_BITS  = rrw_pkg::COORD_BITS_DEFAULT;
    localparam logic [rrw_pkg::INDEX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 31;
    localparam int HOLD_CYCLES = 90;
    localparam int SETTLE      = 8;
    localparam int DRAIN_LIMIT = 5000;
    localparam int PHASES      = 10;
    localparam int PHASE_RECTS = 5;

    // one bus word as it leaves the block
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       last;
    } bus_word_t;

    // window prediction and word ordering check
    class window_scoreboard;
        logic [rrw_pkg::ROT_BITS-1:0]   rot;
        logic [rrw_pkg::PANEL_BITS-1:0] cols;
        logic [rrw_pkg::PANEL_BITS-1:0] rows;
        bus_word_t                      expected_words[$];
        int                             errors;
        int                             rects_framed;

        function void set_reg(logic [rrw_pkg::INDEX_BITS-1:0] idx,
                              logic [rrw_pkg::CFG_BITS-1:0] val);
            if (idx == rrw_pkg::REG_ROTATION)
                rot = val[rrw_pkg::ROT_BITS-1:0];
            else if (idx == rrw_pkg::REG_PANEL_COLUMNS)
                cols = val[rrw_pkg::PANEL_BITS-1:0];
            else if (idx == rrw_pkg::REG_PANEL_ROWS)
                rows = val[rrw_pkg::PANEL_BITS-1:0];
        endfunction

        function void push_word(logic cmd, logic [7:0] data, logic last);
            bus_word_t w;
            w.cmd  = cmd;
            w.data = data;
            w.last = last;
            expected_words.push_back(w);
        endfunction

        // window values go out as 16-bit two's complement, high byte first
        function void push_coord(int v);
            logic [rrw_pkg::WIN_BITS-1:0] u;
            u = v[rrw_pkg::WIN_BITS-1:0];
            push_word(1'b0, u[15:8], 1'b0);
            push_word(1'b0, u[7:0], 1'b0);
        endfunction

        function void note_rect(logic signed [COORD_BITS-1:0] rx,
                                logic signed [COORD_BITS-1:0] ry,
                                logic [rrw_pkg::SIZE_BITS-1:0] rw,
                                logic [rrw_pkg::SIZE_BITS-1:0] rh);
            int x, y, w, h, pw, ph, ext_x, ext_y, c0, c1, r0, r1;
            bit portrait;
            x  = int'(rx);
            y  = int'(ry);
            w  = int'(rw);
            h  = int'(rh);
            pw = int'(cols);
            ph = int'(rows);
            portrait = (rot == rrw_pkg::ROT_LEFT) || (rot == rrw_pkg::ROT_RIGHT);
            ext_x = portrait ? pw : ph;
            ext_y = portrait ? ph : pw;
            // off-panel origin gives no words
            if (x < 0 || y < 0 || x > ext_x || y > ext_y)
                return;
            // clip to the panel edge
            if (x + w > ext_x)
                w = ext_x - x;
            if (y + h > ext_y)
                h = ext_y - y;
            case (rot)
                rrw_pkg::ROT_LEFT:
                begin
                    c0 = x;            c1 = x + w - 1;
                    r0 = y;            r1 = y + h - 1;
                end
                rrw_pkg::ROT_RIGHT:
                begin
                    c0 = pw - (x + w); c1 = pw - x - 1;
                    r0 = ph - (y + h); r1 = ph - y - 1;
                end
                rrw_pkg::ROT_FLIPPED:
                begin
                    c0 = pw - (y + h); c1 = pw - y - 1;
                    r0 = x;            r1 = x + w - 1;
                end
                default:
                begin
                    c0 = y;            c1 = y + h - 1;
                    r0 = ph - (x + w); r1 = ph - x - 1;
                end
            endcase
            push_word(1'b1, rrw_pkg::CMD_COLUMN, 1'b0);
            push_coord(c0);
            push_coord(c1);
            push_word(1'b1, rrw_pkg::CMD_ROW, 1'b0);
            push_coord(r0);
            push_coord(r1);
            push_word(1'b1, rrw_pkg::CMD_MEMORY, 1'b1);
            rects_framed++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_word(logic cmd, logic [7:0] data, logic last);
            bus_word_t exp_w;
            if (expected_words.size() == 0)
                report_mismatch($sformatf("unexpected word cmd=%0b byte=%02h last=%0b",
                                          cmd, data, last));
            else
            begin
                exp_w = expected_words.pop_front();
                if (exp_w.cmd !== cmd || exp_w.data !== data || exp_w.last !== last)
                    report_mismatch($sformatf(
                        "got cmd=%0b byte=%02h last=%0b, want cmd=%0b byte=%02h last=%0b",
                        cmd, data, last, exp_w.cmd, exp_w.data, exp_w.last));
            end
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [rrw_pkg::INDEX_BITS-1:0]    cfg_index;
    logic [rrw_pkg::CFG_BITS-1:0]      cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic signed [COORD_BITS-1:0]      rect_x;
    logic signed [COORD_BITS-1:0]      rect_y;
    logic [rrw_pkg::SIZE_BITS-1:0]     rect_width;
    logic [rrw_pkg::SIZE_BITS-1:0]     rect_height;
    logic                              out_valid;
    logic                              out_stall;
    logic                              is_command;
    logic [7:0]                        bus_byte;
    logic                              last_word;

    window_scoreboard sb;
    bit calm;
    bit hold_req;

    // driver side copy of the panel setup, for aiming coordinates
    logic [rrw_pkg::ROT_BITS-1:0]   cur_rot;
    logic [rrw_pkg::PANEL_BITS-1:0] cur_cols;
    logic [rrw_pkg::PANEL_BITS-1:0] cur_rows;

    rotated_rect_window_command_gen_core #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rect_x     (rect_x),
        .rect_y     (rect_y),
        .rect_width (rect_width),
        .rect_height(rect_height),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_command (is_command),
        .bus_byte   (bus_byte),
        .last_word  (last_word)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard limit on run length
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    // monitor both channels at the edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                sb.note_rect(rect_x, rect_y, rect_width, rect_height);
            if (out_valid && !out_stall)
                sb.check_word(is_command, bus_byte, last_word);
        end
    end

    // receiver: random stalls, one long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic logic [COORD_BITS-1:0] rand_coord(int ext);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return COORD_BITS'($urandom_range(0, ext));
        else if (r < 65)
            return COORD_BITS'(ext);
        else if (r < 72)
            return '0;
        else if (r < 80)
            return COORD_BITS'(ext + 1);
        else
            return COORD_BITS'($urandom);
    endfunction

    function automatic logic [rrw_pkg::SIZE_BITS-1:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return rrw_pkg::SIZE_BITS'($urandom_range(0, 31));
        else if (r < 50)
            return '0;
        else if (r < 65)
            return '1;
        else
            return rrw_pkg::SIZE_BITS'($urandom_range(0, 2047));
    endfunction

    // offer one rectangle word, holding it until accepted
    task automatic send_rect(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                             input logic [rrw_pkg::SIZE_BITS-1:0] w,
                             input logic [rrw_pkg::SIZE_BITS-1:0] h);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        rect_x      <= x;
        rect_y      <= y;
        rect_width  <= w;
        rect_height <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_config(input logic [rrw_pkg::ROT_BITS-1:0] rot,
                                input logic [rrw_pkg::PANEL_BITS-1:0] cols,
                                input logic [rrw_pkg::PANEL_BITS-1:0] rows);
        // let the monitor note the last accepted rectangle first
        @(posedge clk);
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= rrw_pkg::REG_ROTATION;
        cfg_data  <= rrw_pkg::CFG_BITS'(rot);
        @(posedge clk);
        cfg_index <= rrw_pkg::REG_PANEL_COLUMNS;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_index <= rrw_pkg::REG_PANEL_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        // unmapped index must leave the setup alone
        cfg_index <= REG_UNUSED;
        cfg_data  <= rrw_pkg::CFG_BITS'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(rrw_pkg::REG_ROTATION, rrw_pkg::CFG_BITS'(rot));
        sb.set_reg(rrw_pkg::REG_PANEL_COLUMNS, cols);
        sb.set_reg(rrw_pkg::REG_PANEL_ROWS, rows);
        cur_rot  = rot;
        cur_cols = cols;
        cur_rows = rows;
    endtask

    task automatic run_random(input int target);
        int start, tries, ext_x, ext_y;
        bit portrait;
        portrait = (cur_rot == rrw_pkg::ROT_LEFT) || (cur_rot == rrw_pkg::ROT_RIGHT);
        ext_x = portrait ? int'(cur_cols) : int'(cur_rows);
        ext_y = portrait ? int'(cur_rows) : int'(cur_cols);
        start = sb.rects_framed;
        tries = 0;
        while (sb.rects_framed - start < target && tries < 80)
        begin
            send_rect(rand_coord(ext_x), rand_coord(ext_y), rand_size(), rand_size());
            tries++;
        end
        in_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [rrw_pkg::ROT_BITS-1:0]   ph_rot[PHASES];
        logic [rrw_pkg::PANEL_BITS-1:0] ph_cols[PHASES];
        logic [rrw_pkg::PANEL_BITS-1:0] ph_rows[PHASES];
        int drain;

        sb = new();
        sb.rot  = rrw_pkg::ROTATION_RESET;
        sb.cols = rrw_pkg::COLUMNS_RESET;
        sb.rows = rrw_pkg::ROWS_RESET;
        cur_rot  = rrw_pkg::ROTATION_RESET;
        cur_cols = rrw_pkg::COLUMNS_RESET;
        cur_rows = rrw_pkg::ROWS_RESET;
        calm     = 1'b0;
        hold_req = 1'b0;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= rrw_pkg::REG_ROTATION;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        rect_x      <= '0;
        rect_y      <= '0;
        rect_width  <= '0;
        rect_height <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed, reset setup: landscape, extent 480 by 320
        send_rect(12'sd0, 12'sd0, 11'd0, 11'd0);          // empty window
        send_rect(12'sd0, 12'sd0, 11'd1, 11'd1);
        send_rect(12'sd480, 12'sd0, 11'd5, 11'd5);        // x on the edge
        send_rect(12'sd0, 12'sd320, 11'd5, 11'd5);        // y on the edge
        send_rect(12'sd481, 12'sd0, 11'd1, 11'd1);        // beyond extent
        send_rect(12'sd0, 12'sd321, 11'd1, 11'd1);
        send_rect(-12'sd1, 12'sd0, 11'd1, 11'd1);         // negative origin
        send_rect(12'sd0, -12'sd1, 11'd1, 11'd1);
        send_rect(12'h800, 12'h800, 11'd2047, 11'd2047);  // most negative origin
        send_rect(12'sd2047, 12'sd2047, 11'd0, 11'd0);
        send_rect(12'sd0, 12'sd0, 11'd2047, 11'd2047);    // clip both ways
        send_rect(12'sd479, 12'sd319, 11'd2047, 11'd2047);
        send_rect(12'sd100, 12'sd50, 11'd10, 11'd20);
        send_rect(12'sd240, 12'sd160, 11'd0, 11'd2047);
        send_rect(12'sd1365, 12'sd682, 11'd1365, 11'd682);
        in_valid <= 1'b0;

        // panel setups, extremes first
        ph_rot[0] = rrw_pkg::ROT_LEFT;      ph_cols[0] = 11'd320;  ph_rows[0] = 11'd480;
        ph_rot[1] = rrw_pkg::ROT_RIGHT;     ph_cols[1] = 11'd320;  ph_rows[1] = 11'd480;
        ph_rot[2] = rrw_pkg::ROT_FLIPPED;   ph_cols[2] = 11'd320;  ph_rows[2] = 11'd480;
        ph_rot[3] = rrw_pkg::ROT_LANDSCAPE; ph_cols[3] = 11'd2047; ph_rows[3] = 11'd2047;
        ph_rot[4] = rrw_pkg::ROT_LEFT;      ph_cols[4] = 11'd1;    ph_rows[4] = 11'd1;
        ph_rot[5] = rrw_pkg::ROT_RIGHT;     ph_cols[5] = 11'd2047; ph_rows[5] = 11'd1;
        ph_rot[6] = rrw_pkg::ROT_FLIPPED;   ph_cols[6] = 11'd1;    ph_rows[6] = 11'd2047;
        ph_rot[7] = rrw_pkg::ROT_LANDSCAPE; ph_cols[7] = 11'd0;    ph_rows[7] = 11'd0;
        for (int p = 8; p < PHASES; p++)
        begin
            ph_rot[p]  = rrw_pkg::ROT_BITS'($urandom_range(0, 3));
            ph_cols[p] = rrw_pkg::PANEL_BITS'($urandom_range(1, 64));
            ph_rows[p] = rrw_pkg::PANEL_BITS'($urandom_range(1, 2047));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_config(ph_rot[p], ph_cols[p], ph_rows[p]);
            calm = (p == 3) || (p == 4);
            // long output hold while rectangles keep coming
            if (p == 1)
                hold_req = 1'b1;
            run_random(PHASE_RECTS);
        end
        calm = 1'b0;

        // drain, then let the pipeline settle
        @(posedge clk);
        drain = 0;
        while (sb.expected_words.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE * 4) @(posedge clk);
        if (sb.expected_words.size() == 0 && sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/rrw_pkg.sv
sv/rrw_front.sv
sv/rrw_queue.sv
sv/rrw_back.sv
sv/rotated_rect_window_command_gen_core.sv
sim/tb.sv
